// File: rtl/hls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_pkg: shared widths, limits and register map
// Fixed-point formats of the homography local scale pipeline.
// ----------------------------------------------------------------------------
package hls_pkg;

  // input pixels, unsigned Q12.4
  localparam int unsigned PIX_W   = 16;
  // pixel +- 2 px, signed Q.4
  localparam int unsigned OFS_W   = PIX_W + 2;
  // homography coefficient, signed Q12.20
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned PROD_W  = COEF_W + OFS_W;
  // numerators and w, signed Q.24 (|value| < 2^50)
  localparam int unsigned NUM_W   = 52;
  localparam int unsigned MAG_W   = NUM_W - 1;
  // quotient: 20 integer and 20 fraction bits
  localparam int unsigned FRAC_W  = 20;
  localparam int unsigned QUO_W   = 2 * FRAC_W;
  localparam int unsigned CRD_W   = QUO_W + 1;
  // divider pipeline: magnitude, setup, one stage per quotient bit, sign
  localparam int unsigned DIV_LAT = QUO_W + 3;

  localparam logic signed [OFS_W-1:0] STEP_Q4   = OFS_W'(32);
  localparam logic [QUO_W-1:0]        COORD_MAX = '1;

  // Jacobian entry, signed Q.22, saturated to +-(2^30-1)
  localparam int unsigned JAC_W = 31;
  localparam logic signed [JAC_W-1:0] JAC_MAX = {1'b0, {(JAC_W-1){1'b1}}};

  // configuration port
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  localparam int unsigned OUT_W = 24;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [2:0] {
    REG_COEF_PAIR_0 = 3'd0,
    REG_COEF_PAIR_1 = 3'd1,
    REG_COEF_PAIR_2 = 3'd2,
    REG_COEF_PAIR_3 = 3'd3,
    REG_COEF_LAST   = 3'd4,
    REG_MAP_LOADED  = 3'd5
  } hls_reg_e;

endpackage

// File: rtl/hls_qdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_qdiv: pipelined projective divide
// Divides two signed Q.24 numerators by one shared w, giving signed Q.20
// coordinates truncated toward zero, saturated; a zero w gives zero.
// ----------------------------------------------------------------------------
module hls_qdiv import hls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [NUM_W-1:0] num_x_i,
  input  logic signed [NUM_W-1:0] num_y_i,
  input  logic signed [NUM_W-1:0] den_i,
  output logic                    valid_o,
  output logic signed [CRD_W-1:0] crd_x_o,
  output logic signed [CRD_W-1:0] crd_y_o
);

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] dq;   // dividend bits shift out, quotient bits shift in
    logic             neg;
    logic             sat;
  } lane_t;

  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic             wz;
    lane_t [1:0]      ln;
  } step_t;

  function automatic logic [MAG_W-1:0] mag(logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] u;
    u = v[NUM_W-1] ? -v : v;
    return u[MAG_W-1:0];
  endfunction

  // one restoring step: one quotient bit
  function automatic lane_t div_step(lane_t l, logic [MAG_W-1:0] den);
    logic [MAG_W:0] r2;
    logic           ge;
    lane_t          o;
    o     = l;
    r2    = {l.rem, l.dq[QUO_W-1]};
    ge    = (r2 >= {1'b0, den});
    o.rem = ge ? MAG_W'(r2 - {1'b0, den}) : r2[MAG_W-1:0];
    o.dq  = {l.dq[QUO_W-2:0], ge};
    return o;
  endfunction

  logic [DIV_LAT-1:0] vld_q;

  logic [MAG_W-1:0]   magn_q [2];
  logic               neg_q  [2];
  logic [MAG_W-1:0]   magd_q;
  logic               wz_q;

  step_t              stp_q [QUO_W+1];
  step_t              stp_d [QUO_W+1];
  logic signed [CRD_W-1:0] crd_q [2];
  logic signed [CRD_W-1:0] crd_d [2];

  logic signed [NUM_W-1:0] num_in [2];

  assign num_in[0] = num_x_i;
  assign num_in[1] = num_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_LAT-2:0], valid_i};
    end
  end

  always_comb begin
    // setup: integer part of the dividend goes to the remainder
    stp_d[0].den = magd_q;
    stp_d[0].wz  = wz_q;
    for (int j = 0; j < 2; j++) begin
      stp_d[0].ln[j].rem = magn_q[j] >> FRAC_W;
      stp_d[0].ln[j].dq  = {magn_q[j][FRAC_W-1:0], (QUO_W-FRAC_W)'(0)};
      stp_d[0].ln[j].neg = neg_q[j];
      stp_d[0].ln[j].sat = ((magn_q[j] >> FRAC_W) >= magd_q);
    end
    for (int k = 0; k < QUO_W; k++) begin
      stp_d[k+1].den = stp_q[k].den;
      stp_d[k+1].wz  = stp_q[k].wz;
      for (int j = 0; j < 2; j++) begin
        stp_d[k+1].ln[j] = div_step(stp_q[k].ln[j], stp_q[k].den);
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0]        m;
    logic signed [CRD_W-1:0] ms;
    for (int j = 0; j < 2; j++) begin
      m  = stp_q[QUO_W].ln[j].sat ? COORD_MAX : stp_q[QUO_W].ln[j].dq;
      ms = signed'({1'b0, m});
      if (stp_q[QUO_W].wz) begin
        crd_d[j] = '0;
      end else begin
        crd_d[j] = stp_q[QUO_W].ln[j].neg ? -ms : ms;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 2; j++) begin
        magn_q[j] <= mag(num_in[j]);
        neg_q[j]  <= (num_in[j] < 0) != (den_i < 0);
        crd_q[j]  <= crd_d[j];
      end
      magd_q <= mag(den_i);
      wz_q   <= (den_i == '0);
      for (int k = 0; k <= QUO_W; k++) begin
        stp_q[k] <= stp_d[k];
      end
    end
  end

  assign valid_o = vld_q[DIV_LAT-1];
  assign crd_x_o = crd_q[0];
  assign crd_y_o = crd_q[1];

endmodule

// File: rtl/homography_local_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_local_scale: local scale of an image-to-board homography
// Maps four points 2 px around the input pixel, forms the Jacobian by
// central differences and returns its two singular values in Q8.16.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  pixel     in   pixel_valid_i / pixel_stall_o pixel_x_i, pixel_y_i (Q12.4)
//  scale     out  scale_valid_o / scale_stall_i scale_min_o, scale_max_o
//  config    in   APB, 64-bit data, reg i at 8*i coefficients, map_loaded
//
//  One beat per cycle while pixel_stall_o is low; the pipeline holds the
//  40 bit-per-stage divide and the 32 digit-per-stage square roots.
//  Reset clears valid bits and config registers, not the datapath; no clearing pass.
//  A stalled output beat parks in a skid register; the pipeline freezes the
//  cycle after and pixel_stall_o comes from that register alone.
// ----------------------------------------------------------------------------
module homography_local_scale import hls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                pixel_valid_i,
  output logic                pixel_stall_o,
  input  logic [PIX_W-1:0]    pixel_x_i,
  input  logic [PIX_W-1:0]    pixel_y_i,

  output logic                scale_valid_o,
  input  logic                scale_stall_i,
  output logic [OUT_W-1:0]    scale_min_o,
  output logic [OUT_W-1:0]    scale_max_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned SUM_W  = JAC_W + 1;
  localparam int unsigned SQR_W  = 2 * JAC_W;
  localparam int unsigned RAD_W  = SQR_W + 1;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned NSTEP  = ROOT_W;

  typedef struct packed {
    logic [RAD_W-1:0] v;
    logic [RAD_W-1:0] r;
  } root_t;

  // ---------------------------------------------------------------- config
  logic [DATA_W-1:0]  coef_pair_q [4];
  logic [COEF_W-1:0]  coef_last_q;
  logic               map_loaded_q;
  logic               cfg_wr;
  hls_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = hls_reg_e'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coef_pair_q[i] <= '0;
      coef_last_q  <= '0;
      map_loaded_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_COEF_PAIR_0: coef_pair_q[0] <= pwdata;
        REG_COEF_PAIR_1: coef_pair_q[1] <= pwdata;
        REG_COEF_PAIR_2: coef_pair_q[2] <= pwdata;
        REG_COEF_PAIR_3: coef_pair_q[3] <= pwdata;
        REG_COEF_LAST:   coef_last_q    <= pwdata[COEF_W-1:0];
        REG_MAP_LOADED:  map_loaded_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COEF_PAIR_0: prdata = coef_pair_q[0];
      REG_COEF_PAIR_1: prdata = coef_pair_q[1];
      REG_COEF_PAIR_2: prdata = coef_pair_q[2];
      REG_COEF_PAIR_3: prdata = coef_pair_q[3];
      REG_COEF_LAST:   prdata = DATA_W'(coef_last_q);
      REG_MAP_LOADED:  prdata = DATA_W'(map_loaded_q);
      default:         prdata = '0;
    endcase
  end

  // h00..h22 in row order
  logic signed [COEF_W-1:0] h [9];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h[2*i]   = coef_pair_q[i][COEF_W-1:0];
      h[2*i+1] = coef_pair_q[i][DATA_W-1:COEF_W];
    end
    h[8] = coef_last_q;
  end

  // ---------------------------------------------------------- flow control
  logic pipe_en;
  logic skid_vld_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v8_q, v9_q;
  logic [3:0] pt_vld;

  assign pipe_en       = !skid_vld_q;
  assign pixel_stall_o = skid_vld_q;

  // ------------------------------------------------- stage 1: input pixels
  logic [PIX_W-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
  end

  // ------------------------------------------------- stage 2: products
  // xo: x+2, x-2, x     yo: y, y+2, y-2
  logic signed [OFS_W-1:0]  xo [3];
  logic signed [OFS_W-1:0]  yo [3];
  logic signed [PROD_W-1:0] mx_q [3][3];
  logic signed [PROD_W-1:0] my_q [3][3];

  always_comb begin
    xo[0] = signed'(OFS_W'(px_q)) + STEP_Q4;
    xo[1] = signed'(OFS_W'(px_q)) - STEP_Q4;
    xo[2] = signed'(OFS_W'(px_q));
    yo[0] = signed'(OFS_W'(py_q));
    yo[1] = signed'(OFS_W'(py_q)) + STEP_Q4;
    yo[2] = signed'(OFS_W'(py_q)) - STEP_Q4;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          mx_q[r][k] <= h[3*r] * xo[k];
          my_q[r][k] <= h[3*r+1] * yo[k];
        end
      end
    end
  end

  // --------------------------------------- stage 3: nx, ny, w per point
  // points: (x+2,y) (x-2,y) (x,y+2) (x,y-2); rows: nx, ny, w
  logic signed [NUM_W-1:0] num_q [3][4];
  logic signed [NUM_W-1:0] num_d [3][4];

  always_comb begin
    logic signed [NUM_W-1:0] ct;
    for (int r = 0; r < 3; r++) begin
      ct = NUM_W'(h[3*r+2]) <<< 4;
      num_d[r][0] = NUM_W'(mx_q[r][0]) + NUM_W'(my_q[r][0]) + ct;
      num_d[r][1] = NUM_W'(mx_q[r][1]) + NUM_W'(my_q[r][0]) + ct;
      num_d[r][2] = NUM_W'(mx_q[r][2]) + NUM_W'(my_q[r][1]) + ct;
      num_d[r][3] = NUM_W'(mx_q[r][2]) + NUM_W'(my_q[r][2]) + ct;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_q <= num_d;
    end
  end

  // ------------------------------------------------- projective divide
  logic signed [CRD_W-1:0] bx [4];
  logic signed [CRD_W-1:0] by [4];

  for (genvar p = 0; p < 4; p++) begin : g_pt
    hls_qdiv u_qdiv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (v3_q),
      .num_x_i (num_q[0][p]),
      .num_y_i (num_q[1][p]),
      .den_i   (num_q[2][p]),
      .valid_o (pt_vld[p]),
      .crd_x_o (bx[p]),
      .crd_y_o (by[p])
    );
  end

  // ------------------------------------------------- stage 4: Jacobian
  function automatic logic signed [JAC_W-1:0] jac_sat(logic signed [CRD_W:0] v);
    if (v > JAC_MAX) begin
      return JAC_MAX;
    end else if (v < -JAC_MAX) begin
      return -JAC_MAX;
    end
    return v[JAC_W-1:0];
  endfunction

  logic signed [JAC_W-1:0] ja_q, jb_q, jc_q, jd_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ja_q <= jac_sat(CRD_W'(bx[0]) - CRD_W'(bx[1]) + (CRD_W+1)'(0));
      jc_q <= jac_sat((CRD_W+1)'(by[0]) - (CRD_W+1)'(by[1]));
      jb_q <= jac_sat((CRD_W+1)'(bx[2]) - (CRD_W+1)'(bx[3]));
      jd_q <= jac_sat((CRD_W+1)'(by[2]) - (CRD_W+1)'(by[3]));
    end
  end

  // ------------------------------- stage 5: |a-d| |b+c| |a+d| |b-c|
  logic [JAC_W-1:0] e_q [4];
  logic signed [SUM_W-1:0] e_s [4];

  always_comb begin
    e_s[0] = SUM_W'(ja_q) - SUM_W'(jd_q);
    e_s[1] = SUM_W'(jb_q) + SUM_W'(jc_q);
    e_s[2] = SUM_W'(ja_q) + SUM_W'(jd_q);
    e_s[3] = SUM_W'(jb_q) - SUM_W'(jc_q);
  end

  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] u;
    if (pipe_en) begin
      for (int i = 0; i < 4; i++) begin
        u = e_s[i][SUM_W-1] ? -e_s[i] : e_s[i];
        e_q[i] <= u[JAC_W-1:0];
      end
    end
  end

  // ------------------------------------------------- stage 6: squares
  logic [SQR_W-1:0] sq_q [4];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= SQR_W'(e_q[i]) * SQR_W'(e_q[i]);
      end
    end
  end

  // ------------------------------ stage 7 and square roots: P and Q
  function automatic root_t root_step(root_t s, logic [RAD_W-1:0] bitv);
    logic [RAD_W:0] t;
    root_t          o;
    t = {1'b0, s.r} + {1'b0, bitv};
    if ({1'b0, s.v} >= t) begin
      o.v = s.v - t[RAD_W-1:0];
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  root_t            rt_q [NSTEP+1][2];
  root_t            rt_d [NSTEP+1][2];
  logic [NSTEP:0]   rv_q;

  always_comb begin
    logic [RAD_W-1:0] bitv;
    rt_d[0][0].v = RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]);
    rt_d[0][0].r = '0;
    rt_d[0][1].v = RAD_W'(sq_q[2]) + RAD_W'(sq_q[3]);
    rt_d[0][1].r = '0;
    for (int k = 0; k < NSTEP; k++) begin
      bitv = '0;
      bitv[RAD_W-1-2*k] = 1'b1;
      for (int j = 0; j < 2; j++) begin
        rt_d[k+1][j] = root_step(rt_q[k][j], bitv);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rt_q <= rt_d;
    end
  end

  // ------------------------------------------------- stage 8: sum, diff
  logic [ROOT_W-1:0] sp, sq;
  logic [ROOT_W:0]   hi_q;
  logic [ROOT_W-1:0] lo_q;

  assign sp = rt_q[NSTEP][0].r[ROOT_W-1:0];
  assign sq = rt_q[NSTEP][1].r[ROOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      hi_q <= (ROOT_W+1)'(sq) + (ROOT_W+1)'(sp);
      lo_q <= (sq > sp) ? sq - sp : sp - sq;
    end
  end

  // ------------------------------------ stage 9: halve, round, saturate
  function automatic logic [OUT_W-1:0] to_out(logic [ROOT_W:0] s);
    logic [ROOT_W+1:0] t;
    t = ((ROOT_W+2)'(s) + (ROOT_W+2)'(64)) >> 7;
    return (t > (ROOT_W+2)'(OUT_MAX)) ? OUT_MAX : t[OUT_W-1:0];
  endfunction

  logic [OUT_W-1:0] smin_q, smax_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      smin_q <= map_loaded_q ? to_out((ROOT_W+1)'(lo_q)) : '0;
      smax_q <= map_loaded_q ? to_out(hi_q) : '0;
    end
  end

  // ------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      rv_q <= '0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= pixel_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= pt_vld[0];
      v5_q <= v4_q;
      v6_q <= v5_q;
      rv_q <= {rv_q[NSTEP-1:0], v6_q};
      v8_q <= rv_q[NSTEP];
      v9_q <= v8_q;
    end
  end

  // ------------------------------------------------- output and skid
  logic             out_vld_q;
  logic [OUT_W-1:0] out_min_q, out_max_q;
  logic [OUT_W-1:0] skid_min_q, skid_max_q;
  logic             arrive, take, to_out_reg, to_skid;

  assign arrive     = pipe_en & v9_q;
  assign take       = out_vld_q & !scale_stall_i;
  assign to_out_reg = arrive & (!out_vld_q | take);
  assign to_skid    = arrive & out_vld_q & !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) skid_vld_q <= 1'b0;
      end else begin
        if (to_out_reg)  out_vld_q  <= 1'b1;
        else if (take)   out_vld_q  <= 1'b0;
        if (to_skid)     skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_min_q <= skid_min_q;
        out_max_q <= skid_max_q;
      end
    end else if (to_out_reg) begin
      out_min_q <= smin_q;
      out_max_q <= smax_q;
    end
    if (to_skid) begin
      skid_min_q <= smin_q;
      skid_max_q <= smax_q;
    end
  end

  assign scale_valid_o = out_vld_q;
  assign scale_min_o   = out_min_q;
  assign scale_max_o   = out_max_q;

  // ------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid beat held without an output beat");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !scale_stall_i |=> !skid_vld_q && out_vld_q)
    else $error("skid beat not moved to the output");

  a_points_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pt_vld) == 0 || $countones(pt_vld) == 4)
    else $error("divider lanes out of step");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_valid_o |-> scale_min_o <= scale_max_o)
    else $error("smaller scale above larger scale");

endmodule

// File: test/hls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_checker: scoreboard for the homography local scale block
// Watches the pixel and scale channels, computes the singular values of the
// homography Jacobian at each accepted pixel and compares them in order.
// ----------------------------------------------------------------------------
module hls_checker import hls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pixel_valid_i,
  input  logic              pixel_stall_i,
  input  logic [PIX_W-1:0]  pixel_x_i,
  input  logic [PIX_W-1:0]  pixel_y_i,
  input  logic              scale_valid_i,
  input  logic              scale_stall_i,
  input  logic [OUT_W-1:0]  scale_min_i,
  input  logic [OUT_W-1:0]  scale_max_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                seen_o
);

  typedef struct packed {
    logic [OUT_W-1:0] smin;
    logic [OUT_W-1:0] smax;
  } scale_t;

  logic [63:0] coef_pair [4];
  logic [31:0] coef_h22;
  logic        loaded;
  scale_t      scale_q[$];

  assign pending_o = scale_q.size();

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // signed Q.20 quotient, truncated toward zero, magnitude saturated
  function automatic longint board_div(longint n, longint d);
    longint unsigned un, ud, q, r, m;
    un = mag(n);
    ud = mag(d);
    q = un / ud;
    r = un % ud;
    if (q >= (64'd1 << FRAC_W)) begin
      m = (64'd1 << 40) - 1;
    end else begin
      for (int i = 0; i < FRAC_W; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r -= ud;
          q |= 1;
        end
      end
      m = q;
    end
    return ((n < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void map_to_board(longint h[9], longint x, longint y,
                                       output longint bx, output longint by);
    longint nx, ny, w;
    nx = h[0] * x + h[1] * y + h[2] * 16;
    ny = h[3] * x + h[4] * y + h[5] * 16;
    w  = h[6] * x + h[7] * y + h[8] * 16;
    if (w == 0) begin
      bx = 0;
      by = 0;
    end else begin
      bx = board_div(nx, w);
      by = board_div(ny, w);
    end
  endfunction

  function automatic longint clamp_jac(longint v);
    longint lim;
    lim = (64'd1 << 30) - 1;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] to_q16(longint unsigned s);
    longint unsigned r;
    r = (s + 64) >> 7;
    return r > OUT_MAX ? OUT_MAX : r[OUT_W-1:0];
  endfunction

  function automatic scale_t local_scale(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint h[9];
    longint x, y, x0, y0, x1, y1, x2, y2, x3, y3, a, b, c, d;
    longint unsigned sp, sq;
    scale_t s;
    if (!loaded) return '0;
    for (int i = 0; i < 4; i++) begin
      h[2*i]   = longint'($signed(coef_pair[i][31:0]));
      h[2*i+1] = longint'($signed(coef_pair[i][63:32]));
    end
    h[8] = longint'($signed(coef_h22));
    x = px;
    y = py;
    map_to_board(h, x + 32, y, x0, y0);
    map_to_board(h, x - 32, y, x1, y1);
    map_to_board(h, x, y + 32, x2, y2);
    map_to_board(h, x, y - 32, x3, y3);
    a = clamp_jac(x0 - x1);
    c = clamp_jac(y0 - y1);
    b = clamp_jac(x2 - x3);
    d = clamp_jac(y2 - y3);
    sp = floor_sqrt(mag(a - d) * mag(a - d) + mag(b + c) * mag(b + c));
    sq = floor_sqrt(mag(a + d) * mag(a + d) + mag(b - c) * mag(b - c));
    s.smax = to_q16(sq + sp);
    s.smin = to_q16(sq > sp ? sq - sp : sp - sq);
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scale_t exp_s;
    if (!rst_ni) begin
      foreach (coef_pair[i]) coef_pair[i] = '0;
      coef_h22 = '0;
      loaded = 1'b0;
      fail_cnt_o = 0;
      seen_o = 0;
      scale_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[5:3])
          REG_COEF_PAIR_0: coef_pair[0] = pwdata;
          REG_COEF_PAIR_1: coef_pair[1] = pwdata;
          REG_COEF_PAIR_2: coef_pair[2] = pwdata;
          REG_COEF_PAIR_3: coef_pair[3] = pwdata;
          REG_COEF_LAST:   coef_h22 = pwdata[31:0];
          REG_MAP_LOADED:  loaded = pwdata[0];
          default: ;
        endcase
      end
      if (scale_valid_i && !scale_stall_i) begin
        seen_o++;
        if (scale_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("unexpected scale beat %h %h", scale_min_i, scale_max_i);
        end else begin
          exp_s = scale_q.pop_front();
          if (exp_s.smin !== scale_min_i || exp_s.smax !== scale_max_i) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("mismatch at %0t: min exp %h got %h, max exp %h got %h",
                       $time, exp_s.smin, scale_min_i, exp_s.smax, scale_max_i);
          end
        end
      end
      if (pixel_valid_i && !pixel_stall_i) scale_q.push_back(local_scale(pixel_x_i, pixel_y_i));
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: homography local scale testbench
// Loads several homographies over APB, streams pixels with random gaps and
// output stalls, and relies on hls_checker for the expected scales.
// ----------------------------------------------------------------------------
module tb_top;
  import hls_pkg::*;

  localparam int LAT = 85;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              pixel_valid_i = 1'b0;
  logic              pixel_stall_o;
  logic [PIX_W-1:0]  pixel_x_i = '0;
  logic [PIX_W-1:0]  pixel_y_i = '0;
  logic              scale_valid_o;
  logic              scale_stall_i = 1'b0;
  logic [OUT_W-1:0]  scale_min_o, scale_max_o;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_cnt, pending, seen;
  int                send_idle = 29, recv_idle = 78;
  bit                hold_off = 1'b0;
  int                n_items = 0, n_cfg = 0;

  always #5 clk_i = ~clk_i;

  homography_local_scale u_top (.*);

  hls_checker u_chk (
    .clk_i, .rst_ni, .pixel_valid_i, .pixel_stall_i(pixel_stall_o), .pixel_x_i, .pixel_y_i,
    .scale_valid_i(scale_valid_o), .scale_stall_i, .scale_min_i(scale_min_o),
    .scale_max_i(scale_max_o), .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .seen_o(seen)
  );

  // receiver stall, redrawn every falling edge
  always @(negedge clk_i) begin
    scale_stall_i <= hold_off || ($urandom_range(99) < recv_idle);
  end

  initial begin
    #50ms;
    $display("FAIL homography_local_scale");
    $finish;
  end

  task automatic reg_write(hls_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 3; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    n_cfg++;
  endtask

  task automatic load_map(logic [31:0] h[9], bit en);
    reg_write(REG_COEF_PAIR_0, {h[1], h[0]});
    reg_write(REG_COEF_PAIR_1, {h[3], h[2]});
    reg_write(REG_COEF_PAIR_2, {h[5], h[4]});
    reg_write(REG_COEF_PAIR_3, {h[7], h[6]});
    reg_write(REG_COEF_LAST, {32'(0), h[8]});
    reg_write(REG_MAP_LOADED, {63'(0), en});
  endtask

  // one pixel beat; valid held high across back-to-back beats
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    while ($urandom_range(99) < send_idle) begin
      pixel_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    @(posedge clk_i);
    while (pixel_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
  endtask

  task automatic drain();
    pixel_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coef(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2097151)) - 32'sd1048576;
      default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  initial begin
    logic [31:0] h[9];
    int phase;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    // unloaded map gives zero scales
    send_pixel('0, '0);
    send_pixel('1, '1);
    drain();
    // plain scaling, then a projective map with shear
    h = '{32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 0, 0, 32'h0010_0000};
    load_map(h, 1);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(16'h8000, 16'h0001);
    drain();
    h = '{32'h0020_0000, 32'h0008_0000, 32'h0100_0000, 32'hfff8_0000, 32'h0030_0000,
          32'h0000_1000, 32'h0000_0100, 32'hffff_ff00, 32'h0010_0000};
    load_map(h, 1);
    for (int i = 0; i < 6; i++) send_pixel(16'(i * 13107), 16'(65535 - i * 13107));
    drain();
    // zero w everywhere, and extreme coefficients to saturate
    h = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 0, 0, 0};
    load_map(h, 1);
    send_pixel(16'h1234, 16'h4321);
    drain();
    h[8] = 32'h0000_0001;
    load_map(h, 1);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel(16'h0020, 16'h0020);
    drain();
    // w crossing zero near a pixel
    h = '{32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 32'h0001_0000, 0, 32'hfff0_0000};
    load_map(h, 1);
    send_pixel(16'h0100, 16'h0100);
    send_pixel(16'h0120, 16'h0000);
    drain();
    // long output hold-off so the pipeline backs up into the input
    hold_off = 1'b1;
    fork
      repeat (400) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
    for (phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 29 : phase == 1 ? 78 : 0;
      recv_idle = phase == 0 ? 78 : phase == 1 ? 29 : 0;
      for (int m = 0; m < 4; m++) begin
        foreach (h[i]) h[i] = rnd_coef(((m + phase) % 4 == 3) ? 2 : (m % 2));
        if ($urandom_range(3) == 0) h[6] = 0;
        if ($urandom_range(3) == 0) h[7] = 0;
        load_map(h, m != 1 || phase != 2);
        repeat (80) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
        drain();
      end
    end
    $display("Covered %0d pixels over %0d register writes with directed corner maps,",
             n_items, n_cfg);
    $display("random maps, zero and saturated w, and a long output hold-off.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS homography_local_scale");
    end else begin
      $display("FAIL homography_local_scale");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hls_pkg.sv
rtl/hls_qdiv.sv
rtl/homography_local_scale.sv
test/hls_checker.sv
test/tb_top.sv
